### src/uniform_grid_pair_finder_macros.svh
// ----------------------------------------------------------------------------
// uniform grid pair finder assertion macros
// shared helpers for concurrent checks on the block ports
// ----------------------------------------------------------------------------
`ifndef UNIFORM_GRID_PAIR_FINDER_MACROS_SVH
`define UNIFORM_GRID_PAIR_FINDER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define UGPF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ugpf check failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define UGPF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ugpf check failed: next-cycle implication");

`endif

### src/ugpf_pkg.sv
// ----------------------------------------------------------------------------
// ugpf_pkg
// shared types, codes and field layout of the uniform grid pair finder
// ----------------------------------------------------------------------------
package ugpf_pkg;

  localparam int unsigned DEF_MAX_BODIES = 1024;
  localparam int unsigned DEF_MAX_COLS   = 32;
  localparam int unsigned DEF_MAX_ROWS   = 32;

  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned BODY_W     = 10;
  localparam int unsigned POS_W      = 17;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned SHIFT_W    = 4;

  // input word: func, body_index, pos_x, pos_y
  localparam int unsigned IN_TDATA_W  = 48;
  // output word: status, first_body, second_body
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [CFG_DATA_W-1:0] COLS_RST  = 6'd32;
  localparam logic [CFG_DATA_W-1:0] ROWS_RST  = 6'd32;
  localparam logic [SHIFT_W-1:0]    SHIFT_RST = 4'd10;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR     = 2'd0,
    FUNC_INSERT    = 2'd1,
    FUNC_NEXT_PAIR = 2'd2,
    FUNC_NONE      = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_PAIR = 2'd0,
    STATUS_DONE = 2'd1,
    STATUS_ACK  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLS  = 2'd0,
    CFG_GRID_ROWS  = 2'd1,
    CFG_CELL_SHIFT = 2'd2
  } cfg_idx_e;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_CLR    = 13'b0000000000010,
    ST_DIV    = 13'b0000000000100,
    ST_CHECK  = 13'b0000000001000,
    ST_NBH    = 13'b0000000010000,
    ST_OUT    = 13'b0000000100000,
    ST_OUTH   = 13'b0000001000000,
    ST_OUTL   = 13'b0000010000000,
    ST_INSET  = 13'b0000100000000,
    ST_INL    = 13'b0001000000000,
    ST_INS_RD = 13'b0010000000000,
    ST_INS_WR = 13'b0100000000000,
    ST_RESP   = 13'b1000000000000
  } state_e;

endpackage

### src/ugpf_ram.sv
// ----------------------------------------------------------------------------
// ugpf_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ugpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/uniform_grid_pair_finder.sv
// ----------------------------------------------------------------------------
// uniform_grid_pair_finder
// broad-phase grid: linked cell lists in ram, one candidate pair per request
// ----------------------------------------------------------------------------
// Timing: after reset and for every clear command the head ram is swept one
// cell a cycle, with the input held off. An insert runs through cell
// compute, head read, head and link write and response to its acknowledge.
// A next_pair request runs through accept, check and response once the
// walk is over, and through accept, check, pair read, link read and
// response when its pair is ready at once, with a neighbour head read
// added in a neighbour phase. Each walk step it passes over adds a check
// per out-of-grid neighbour, a check and head read per empty neighbour, a
// check and head read per empty own cell (and a neighbour head read in a
// neighbour phase), and an outer body fetch from the head or a link plus a
// link read in the own cell for the new inner body, all bound by the single
// read port of each ram. After a geometry write the first next_pair request
// rederives the walk row and column by restoring division. The result word
// sits in an output register, so the next word can be taken while it waits.
module uniform_grid_pair_finder import ugpf_pkg::*; #(
  parameter int unsigned MAX_BODIES = DEF_MAX_BODIES,
  parameter int unsigned MAX_COLS   = DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS   = DEF_MAX_ROWS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // func[1:0], body_index[11:2], pos_x[28:12], pos_y[45:29]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // status[1:0], first_body[11:2], second_body[21:12]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned NUM_CELLS = MAX_COLS * MAX_ROWS;
  localparam int unsigned CELL_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int unsigned CW1       = $clog2(NUM_CELLS + 1);
  localparam int unsigned BI_W      = $clog2(MAX_BODIES);
  localparam int unsigned PTR_W     = $clog2(MAX_BODIES + 1);
  localparam int unsigned CI_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RI_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned EC_W      = $clog2(MAX_COLS + 1);
  localparam int unsigned ER_W      = $clog2(MAX_ROWS + 1);
  localparam int unsigned DCNT_W    = $clog2(CW1 + 1);

  localparam logic [PTR_W-1:0]  NIL       = PTR_W'(MAX_BODIES);
  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(NUM_CELLS - 1);

  localparam logic [2:0] PH_SELF = 3'd0;
  localparam logic [2:0] PH_E    = 3'd1;
  localparam logic [2:0] PH_SW   = 3'd2;
  localparam logic [2:0] PH_S    = 3'd3;
  localparam logic [2:0] PH_SE   = 3'd4;

  // floor shift, negative to zero, clamp to the last index
  function automatic logic [15:0] pos_to_idx(input logic [POS_W-1:0] v,
                                             input logic [SHIFT_W-1:0] sh,
                                             input logic [15:0] lim);
    logic [15:0] q;
    q = v[15:0] >> sh;
    if (v[POS_W-1]) begin
      q = '0;
    end else if (q > lim - 16'd1) begin
      q = lim - 16'd1;
    end
    return q;
  endfunction

  // input unpack
  func_e              in_func;
  logic [BODY_W-1:0]  in_body;
  logic [POS_W-1:0]   in_pos_x;
  logic [POS_W-1:0]   in_pos_y;

  assign in_func  = func_e'(s_axis_tdata_i[1:0]);
  assign in_body  = s_axis_tdata_i[11:2];
  assign in_pos_x = s_axis_tdata_i[28:12];
  assign in_pos_y = s_axis_tdata_i[45:29];

  // configuration
  logic [CFG_DATA_W-1:0] cols_q, rows_q;
  logic [SHIFT_W-1:0]    shift_q;
  logic [EC_W-1:0]       eff_cols;
  logic [ER_W-1:0]       eff_rows;
  logic [CW1-1:0]        ncells;

  always_comb begin
    if (cols_q == '0) begin
      eff_cols = EC_W'(1);
    end else if (32'(cols_q) > MAX_COLS) begin
      eff_cols = EC_W'(MAX_COLS);
    end else begin
      eff_cols = EC_W'(cols_q);
    end
    if (rows_q == '0) begin
      eff_rows = ER_W'(1);
    end else if (32'(rows_q) > MAX_ROWS) begin
      eff_rows = ER_W'(MAX_ROWS);
    end else begin
      eff_rows = ER_W'(rows_q);
    end
  end

  assign ncells = CW1'(CW1'(eff_cols) * CW1'(eff_rows));

  // control state
  state_e             state_q, state_d;
  logic [CELL_W-1:0]  clr_q, clr_d;
  logic               clr_ack_q, clr_ack_d;
  logic [CW1-1:0]     walk_cell_q, walk_cell_d;
  logic [RI_W-1:0]    walk_row_q, walk_row_d;
  logic [CI_W-1:0]    walk_col_q, walk_col_d;
  logic [2:0]         phase_q, phase_d;
  logic [PTR_W-1:0]   outer_q, outer_d;
  logic [PTR_W-1:0]   inner_q, inner_d;
  logic               done_q, done_d;
  logic               dirty_q, dirty_d;
  logic               out_valid_q, out_valid_d;

  // payload
  logic [PTR_W-1:0]   nb_head_q, nb_head_d;
  logic [CI_W-1:0]    ins_col_q, ins_col_d;
  logic [RI_W-1:0]    ins_row_q, ins_row_d;
  logic [BODY_W-1:0]  ins_body_q, ins_body_d;
  logic [CELL_W-1:0]  ins_cell_q, ins_cell_d;
  logic [CW1-1:0]     div_dvd_q, div_dvd_d;
  logic [CW1-1:0]     div_quo_q, div_quo_d;
  logic [EC_W-1:0]    div_rem_q, div_rem_d;
  logic [DCNT_W-1:0]  div_cnt_q, div_cnt_d;
  status_e            res_status_q, res_status_d;
  logic [BODY_W-1:0]  res_first_q, res_first_d;
  logic [BODY_W-1:0]  res_second_q, res_second_d;
  status_e            out_status_q, out_status_d;
  logic [BODY_W-1:0]  out_first_q, out_first_d;
  logic [BODY_W-1:0]  out_second_q, out_second_d;

  // ram ports
  logic               heads_we, heads_re;
  logic [CELL_W-1:0]  heads_waddr, heads_raddr;
  logic [PTR_W-1:0]   heads_wdata, heads_rdata;
  logic               links_we, links_re;
  logic [BI_W-1:0]    links_waddr, links_raddr;
  logic [PTR_W-1:0]   links_wdata, links_rdata;

  // walk helpers
  logic               walk_restart, adv_phase;
  logic               has_e, has_w, has_s, nb_ok;
  logic [CW1-1:0]     nb_cell;
  logic [EC_W:0]      div_rem_s;
  logic [EC_W-1:0]    div_rem_n;
  logic               div_qbit;

  assign has_e = (EC_W'(walk_col_q) + EC_W'(1)) < eff_cols;
  assign has_w = walk_col_q != '0;
  assign has_s = (ER_W'(walk_row_q) + ER_W'(1)) < eff_rows;

  always_comb begin
    case (phase_q)
      PH_E: begin
        nb_ok   = has_e;
        nb_cell = walk_cell_q + CW1'(1);
      end
      PH_SW: begin
        nb_ok   = has_s && has_w;
        nb_cell = walk_cell_q + CW1'(eff_cols) - CW1'(1);
      end
      PH_S: begin
        nb_ok   = has_s;
        nb_cell = walk_cell_q + CW1'(eff_cols);
      end
      PH_SE: begin
        nb_ok   = has_s && has_e;
        nb_cell = walk_cell_q + CW1'(eff_cols) + CW1'(1);
      end
      default: begin
        nb_ok   = 1'b0;
        nb_cell = walk_cell_q;
      end
    endcase
  end

  // one restoring division step per cycle for the walk row and column
  assign div_rem_s = {div_rem_q, div_dvd_q[CW1-1]};
  assign div_qbit  = div_rem_s >= {1'b0, eff_cols};
  assign div_rem_n = div_qbit ? EC_W'(div_rem_s - {1'b0, eff_cols}) : EC_W'(div_rem_s);

  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    clr_ack_d    = clr_ack_q;
    walk_cell_d  = walk_cell_q;
    walk_row_d   = walk_row_q;
    walk_col_d   = walk_col_q;
    phase_d      = phase_q;
    outer_d      = outer_q;
    inner_d      = inner_q;
    done_d       = done_q;
    dirty_d      = dirty_q;
    out_valid_d  = out_valid_q;
    nb_head_d    = nb_head_q;
    ins_col_d    = ins_col_q;
    ins_row_d    = ins_row_q;
    ins_body_d   = ins_body_q;
    ins_cell_d   = ins_cell_q;
    div_dvd_d    = div_dvd_q;
    div_quo_d    = div_quo_q;
    div_rem_d    = div_rem_q;
    div_cnt_d    = div_cnt_q;
    res_status_d = res_status_q;
    res_first_d  = res_first_q;
    res_second_d = res_second_q;
    out_status_d = out_status_q;
    out_first_d  = out_first_q;
    out_second_d = out_second_q;
    heads_we     = 1'b0;
    heads_waddr  = clr_q;
    heads_wdata  = NIL;
    heads_re     = 1'b0;
    heads_raddr  = walk_cell_q[CELL_W-1:0];
    links_we     = 1'b0;
    links_waddr  = BI_W'(ins_body_q);
    links_wdata  = heads_rdata;
    links_re     = 1'b0;
    links_raddr  = BI_W'(outer_q);
    walk_restart = 1'b0;
    adv_phase    = 1'b0;

    if (m_axis_tvalid_o && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          res_status_d = STATUS_ACK;
          res_first_d  = '0;
          res_second_d = '0;
          case (in_func)
            FUNC_CLEAR: begin
              clr_d        = '0;
              clr_ack_d    = 1'b1;
              walk_restart = 1'b1;
              state_d      = ST_CLR;
            end
            FUNC_INSERT: begin
              walk_restart = 1'b1;
              if (32'(in_body) < MAX_BODIES) begin
                ins_body_d = in_body;
                ins_col_d  = CI_W'(pos_to_idx(in_pos_x, shift_q, 16'(eff_cols)));
                ins_row_d  = RI_W'(pos_to_idx(in_pos_y, shift_q, 16'(eff_rows)));
                state_d    = ST_INS_RD;
              end else begin
                state_d = ST_RESP;
              end
            end
            FUNC_NEXT_PAIR: begin
              div_dvd_d = walk_cell_q;
              div_quo_d = '0;
              div_rem_d = '0;
              div_cnt_d = '0;
              state_d   = dirty_q ? ST_DIV : ST_CHECK;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_CLR: begin
        heads_we = 1'b1;
        clr_d    = clr_q + CELL_W'(1);
        if (clr_q == LAST_CELL) begin
          state_d = clr_ack_q ? ST_RESP : ST_IDLE;
        end
      end
      ST_INS_RD: begin
        ins_cell_d  = CELL_W'(CW1'(ins_row_q) * CW1'(eff_cols) + CW1'(ins_col_q));
        heads_re    = 1'b1;
        heads_raddr = CELL_W'(CW1'(ins_row_q) * CW1'(eff_cols) + CW1'(ins_col_q));
        state_d     = ST_INS_WR;
      end
      ST_INS_WR: begin
        // new body becomes the list head, old head becomes its link
        links_we    = 1'b1;
        heads_we    = 1'b1;
        heads_waddr = ins_cell_q;
        heads_wdata = PTR_W'(ins_body_q);
        state_d     = ST_RESP;
      end
      ST_DIV: begin
        div_rem_d = div_rem_n;
        div_quo_d = CW1'({div_quo_q, div_qbit});
        div_dvd_d = div_dvd_q << 1;
        div_cnt_d = div_cnt_q + DCNT_W'(1);
        if (div_cnt_q == DCNT_W'(CW1 - 1)) begin
          walk_col_d = CI_W'(div_rem_n);
          walk_row_d = RI_W'(CW1'({div_quo_q, div_qbit}));
          dirty_d    = 1'b0;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (done_q) begin
          res_status_d = STATUS_DONE;
          res_first_d  = '0;
          res_second_d = '0;
          state_d      = ST_RESP;
        end else if (walk_cell_q >= ncells) begin
          done_d       = 1'b1;
          res_status_d = STATUS_DONE;
          res_first_d  = '0;
          res_second_d = '0;
          state_d      = ST_RESP;
        end else if (phase_q != PH_SELF) begin
          if (!nb_ok) begin
            adv_phase = 1'b1;
          end else begin
            heads_re    = 1'b1;
            heads_raddr = CELL_W'(nb_cell);
            state_d     = ST_NBH;
          end
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_NBH: begin
        nb_head_d = heads_rdata;
        if (heads_rdata == NIL) begin
          adv_phase = 1'b1;
          state_d   = ST_CHECK;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (outer_q == NIL) begin
          heads_re = 1'b1;
          state_d  = ST_OUTH;
        end else if (inner_q == NIL) begin
          links_re = 1'b1;
          state_d  = ST_OUTL;
        end else begin
          res_status_d = STATUS_PAIR;
          res_first_d  = BODY_W'(outer_q);
          res_second_d = BODY_W'(inner_q);
          links_re     = 1'b1;
          links_raddr  = BI_W'(inner_q);
          state_d      = ST_INL;
        end
      end
      ST_OUTH, ST_OUTL: begin
        // new outer body from the cell head or from the outer link
        outer_d = (state_q == ST_OUTH) ? heads_rdata : links_rdata;
        if (outer_d == NIL) begin
          adv_phase = 1'b1;
          state_d   = ST_CHECK;
        end else if (phase_q == PH_SELF) begin
          links_re    = 1'b1;
          links_raddr = BI_W'(outer_d);
          state_d     = ST_INSET;
        end else begin
          inner_d = nb_head_q;
          state_d = ST_OUT;
        end
      end
      ST_INSET: begin
        inner_d = links_rdata;
        state_d = ST_OUT;
      end
      ST_INL: begin
        inner_d = links_rdata;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_first_d  = res_first_q;
          out_second_d = res_second_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (adv_phase) begin
      outer_d = NIL;
      inner_d = NIL;
      if (phase_q == PH_SE) begin
        phase_d     = PH_SELF;
        walk_cell_d = walk_cell_q + CW1'(1);
        if (!has_e) begin
          walk_col_d = '0;
          walk_row_d = walk_row_q + RI_W'(1);
        end else begin
          walk_col_d = walk_col_q + CI_W'(1);
        end
      end else begin
        phase_d = phase_q + 3'd1;
      end
    end

    if (walk_restart) begin
      walk_cell_d = '0;
      walk_row_d  = '0;
      walk_col_d  = '0;
      phase_d     = PH_SELF;
      outer_d     = NIL;
      inner_d     = NIL;
      done_d      = 1'b0;
      dirty_d     = 1'b0;
    end

    // geometry change invalidates the tracked row and column
    if (cfg_we_i) begin
      dirty_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      clr_ack_q   <= 1'b0;
      walk_cell_q <= '0;
      walk_row_q  <= '0;
      walk_col_q  <= '0;
      phase_q     <= PH_SELF;
      outer_q     <= NIL;
      inner_q     <= NIL;
      done_q      <= 1'b0;
      dirty_q     <= 1'b0;
      out_valid_q <= 1'b0;
      cols_q      <= COLS_RST;
      rows_q      <= ROWS_RST;
      shift_q     <= SHIFT_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clr_ack_q   <= clr_ack_d;
      walk_cell_q <= walk_cell_d;
      walk_row_q  <= walk_row_d;
      walk_col_q  <= walk_col_d;
      phase_q     <= phase_d;
      outer_q     <= outer_d;
      inner_q     <= inner_d;
      done_q      <= done_d;
      dirty_q     <= dirty_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GRID_COLS:  cols_q  <= cfg_wdata_i;
          CFG_GRID_ROWS:  rows_q  <= cfg_wdata_i;
          CFG_CELL_SHIFT: shift_q <= cfg_wdata_i[SHIFT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    nb_head_q    <= nb_head_d;
    ins_col_q    <= ins_col_d;
    ins_row_q    <= ins_row_d;
    ins_body_q   <= ins_body_d;
    ins_cell_q   <= ins_cell_d;
    div_dvd_q    <= div_dvd_d;
    div_quo_q    <= div_quo_d;
    div_rem_q    <= div_rem_d;
    div_cnt_q    <= div_cnt_d;
    res_status_q <= res_status_d;
    res_first_q  <= res_first_d;
    res_second_q <= res_second_d;
    out_status_q <= out_status_d;
    out_first_q  <= out_first_d;
    out_second_q <= out_second_d;
  end

  ugpf_ram #(
    .WIDTH (PTR_W),
    .DEPTH (NUM_CELLS)
  ) u_heads (
    .clk_i   (clk_i),
    .we_i    (heads_we),
    .waddr_i (heads_waddr),
    .wdata_i (heads_wdata),
    .re_i    (heads_re),
    .raddr_i (heads_raddr),
    .rdata_o (heads_rdata)
  );

  ugpf_ram #(
    .WIDTH (PTR_W),
    .DEPTH (MAX_BODIES)
  ) u_links (
    .clk_i   (clk_i),
    .we_i    (links_we),
    .waddr_i (links_waddr),
    .wdata_i (links_wdata),
    .re_i    (links_re),
    .raddr_i (links_raddr),
    .rdata_o (links_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_second_q, out_first_q, out_status_q};

endmodule

### src/ugpf_checker.sv
// ----------------------------------------------------------------------------
// ugpf_checker
// port-level checks of the uniform grid pair finder, bound to the top level
// ----------------------------------------------------------------------------
`include "uniform_grid_pair_finder_macros.svh"

module ugpf_checker import ugpf_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i
);

  logic out_stall;
  logic non_pair;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign non_pair  = m_axis_tdata_o[1:0] != STATUS_PAIR;

  `UGPF_ASSERT_NXT(a_out_valid_held, clk_i, rst_ni, out_stall, m_axis_tvalid_o)

  `UGPF_ASSERT_NXT(a_out_word_held, clk_i, rst_ni, out_stall, $stable(m_axis_tdata_o))

  // only a pair carries body numbers
  `UGPF_ASSERT_IMP(a_no_pair_zero, clk_i, rst_ni, m_axis_tvalid_o && non_pair, m_axis_tdata_o[21:2] == '0)

  // every taken word holds the input off in the cycle after it is taken
  `UGPF_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

endmodule

bind uniform_grid_pair_finder ugpf_checker u_ugpf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

### test/uniform_grid_pair_finder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uniform_grid_pair_finder_test
// streams clear, insert and next_pair commands into the grid pair finder,
// predicts every reply word with an in-bench copy of the cell lists and walk
// state, and compares each reply field by field under random stalls
// ----------------------------------------------------------------------------
module uniform_grid_pair_finder_test;
  import ugpf_pkg::*;

  localparam int unsigned CELLS       = DEF_MAX_COLS * DEF_MAX_ROWS;
  localparam logic [10:0] NO_BODY     = 11'(DEF_MAX_BODIES);
  localparam int unsigned RUN_CMDS    = 1550;
  // a full-grid walk with empty neighbours plus a clear sweep, with margin
  localparam int unsigned STALL_LIMIT = 200000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  // walk phases: own cell, then the four forward neighbours
  localparam int unsigned PH_OWN        = 0;
  localparam int unsigned PH_RIGHT      = 1;
  localparam int unsigned PH_DOWN_LEFT  = 2;
  localparam int unsigned PH_DOWN       = 3;
  localparam int unsigned PH_DOWN_RIGHT = 4;

  typedef struct packed {
    func_e            func;
    logic [BODY_W-1:0] body;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
  } grid_cmd_t;

  typedef struct packed {
    status_e           status;
    logic [BODY_W-1:0] first_body;
    logic [BODY_W-1:0] second_body;
  } pair_reply_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;

  uniform_grid_pair_finder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // grid model state
  logic [10:0]        head_of_cell [CELLS];
  logic [10:0]        next_in_cell [DEF_MAX_BODIES];
  int unsigned        scan_cell;
  int unsigned        scan_phase;
  logic [10:0]        scan_outer;
  logic [10:0]        scan_inner;
  bit                 scan_over;
  logic [5:0]         cols_reg  = COLS_RST;
  logic [5:0]         rows_reg  = ROWS_RST;
  logic [3:0]         shift_reg = SHIFT_RST;

  grid_cmd_t          cmds_waiting [$];
  pair_reply_t        replies_due [$];
  grid_cmd_t          bus_cmd;
  pair_reply_t        want;
  bit                 word_in_taken;
  bit                 word_out_taken;
  int unsigned        cmds_queued;
  int unsigned        words_accepted;
  int unsigned        useful_cmds;
  int unsigned        stall_cycles;
  int unsigned        error_cnt;
  int unsigned        pairs_seen;
  int unsigned        walks_done;
  int unsigned        geometry_sets;
  int unsigned        send_gap_pct = 27;
  int unsigned        recv_gap_pct = 60;
  bit                 body_taken [DEF_MAX_BODIES];
  int unsigned        taken_cnt;

  function automatic int unsigned used_dim(logic [5:0] v, int unsigned cap);
    if (v == 0) return 1;
    return (v > cap) ? cap : int'(v);
  endfunction

  function automatic int unsigned pos_cell(logic [POS_W-1:0] p, int unsigned lim);
    int unsigned q;
    if (p[POS_W-1]) return 0;  // negative lands in the first row or column
    q = int'(p >> shift_reg);
    return (q > lim - 1) ? lim - 1 : q;
  endfunction

  function automatic logic [10:0] body_after(logic [10:0] b);
    return (b < NO_BODY) ? next_in_cell[b[BODY_W-1:0]] : NO_BODY;
  endfunction

  function automatic void restart_scan();
    scan_cell  = 0;
    scan_phase = PH_OWN;
    scan_outer = NO_BODY;
    scan_inner = NO_BODY;
    scan_over  = 1'b0;
  endfunction

  function automatic void advance_phase();
    scan_phase++;
    if (scan_phase > PH_DOWN_RIGHT) begin
      scan_phase = PH_OWN;
      scan_cell++;
    end
    scan_outer = NO_BODY;
    scan_inner = NO_BODY;
  endfunction

  function automatic bit find_next_pair(output logic [BODY_W-1:0] a,
                                        output logic [BODY_W-1:0] b);
    int unsigned cols;
    int unsigned rows;
    int          r;
    int          c;
    int          dr;
    int          dc;
    logic [10:0] nb_head;
    cols = used_dim(cols_reg, DEF_MAX_COLS);
    rows = used_dim(rows_reg, DEF_MAX_ROWS);
    a = '0;
    b = '0;
    while (1'b1) begin
      nb_head = NO_BODY;
      if (scan_over) return 1'b0;
      if (scan_cell >= cols * rows) begin
        scan_over = 1'b1;
        return 1'b0;
      end
      if (scan_phase != PH_OWN) begin
        case (scan_phase)
          PH_RIGHT:     begin dr = 0; dc = 1;  end
          PH_DOWN_LEFT: begin dr = 1; dc = -1; end
          PH_DOWN:      begin dr = 1; dc = 0;  end
          default:      begin dr = 1; dc = 1;  end
        endcase
        r = int'(scan_cell / cols) + dr;
        c = int'(scan_cell % cols) + dc;
        if (r < 0 || r >= int'(rows) || c < 0 || c >= int'(cols)) begin
          advance_phase();
          continue;
        end
        nb_head = head_of_cell[r * int'(cols) + c];
        if (nb_head == NO_BODY) begin
          advance_phase();
          continue;
        end
      end
      if (scan_outer == NO_BODY) begin
        scan_outer = head_of_cell[scan_cell];
        if (scan_outer == NO_BODY) begin
          advance_phase();
          continue;
        end
        scan_inner = (scan_phase == PH_OWN) ? body_after(scan_outer) : nb_head;
        continue;
      end
      if (scan_inner == NO_BODY) begin
        scan_outer = body_after(scan_outer);
        if (scan_outer == NO_BODY) begin
          advance_phase();
          continue;
        end
        scan_inner = (scan_phase == PH_OWN) ? body_after(scan_outer) : nb_head;
        continue;
      end
      a = scan_outer[BODY_W-1:0];
      b = scan_inner[BODY_W-1:0];
      scan_inner = body_after(scan_inner);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic pair_reply_t apply_command(grid_cmd_t cmd);
    pair_reply_t       rep;
    int unsigned       cols;
    int unsigned       rows;
    int unsigned       cell_no;
    logic [BODY_W-1:0] a;
    logic [BODY_W-1:0] b;
    rep.status      = STATUS_ACK;
    rep.first_body  = '0;
    rep.second_body = '0;
    case (cmd.func)
      FUNC_CLEAR: begin
        foreach (head_of_cell[i]) head_of_cell[i] = NO_BODY;
        restart_scan();
      end
      FUNC_INSERT: begin
        cols = used_dim(cols_reg, DEF_MAX_COLS);
        rows = used_dim(rows_reg, DEF_MAX_ROWS);
        cell_no = pos_cell(cmd.pos_y, rows) * cols + pos_cell(cmd.pos_x, cols);
        next_in_cell[cmd.body] = head_of_cell[cell_no];
        head_of_cell[cell_no] = {1'b0, cmd.body};
        restart_scan();
      end
      FUNC_NEXT_PAIR: begin
        if (find_next_pair(a, b)) begin
          rep.status      = STATUS_PAIR;
          rep.first_body  = a;
          rep.second_body = b;
        end else begin
          rep.status = STATUS_DONE;
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  // sender: new word only when the bus is empty or its word was just taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || word_in_taken) begin
        if (cmds_waiting.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          bus_cmd = cmds_waiting.pop_front();
          s_axis_tdata_i  <= {2'b00, bus_cmd.pos_y, bus_cmd.pos_x, bus_cmd.body,
                              bus_cmd.func};
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      word_in_taken  = s_axis_tvalid_i && s_axis_tready_o;
      word_out_taken = m_axis_tvalid_o && m_axis_tready_i;
      if (word_in_taken) begin
        replies_due.push_back(apply_command(bus_cmd));
        words_accepted++;
      end
      if (word_out_taken) begin
        if (replies_due.size() == 0) begin
          $error("reply word %h with no command outstanding", m_axis_tdata_o);
          error_cnt++;
        end else begin
          want = replies_due.pop_front();
          if (m_axis_tdata_o[1:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tdata_o[1:0]);
            error_cnt++;
          end
          if (m_axis_tdata_o[11:2] !== want.first_body) begin
            $error("first_body: expected %0d, got %0d", want.first_body,
                   m_axis_tdata_o[11:2]);
            error_cnt++;
          end
          if (m_axis_tdata_o[21:12] !== want.second_body) begin
            $error("second_body: expected %0d, got %0d", want.second_body,
                   m_axis_tdata_o[21:12]);
            error_cnt++;
          end
          if (want.status == STATUS_PAIR) pairs_seen++;
          if (want.status == STATUS_DONE) walks_done++;
        end
      end
      if (word_in_taken || word_out_taken) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  task automatic queue_cmd(input func_e f, input logic [BODY_W-1:0] body,
                           input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
    grid_cmd_t cmd;
    cmd.func  = f;
    cmd.body  = body;
    cmd.pos_x = px;
    cmd.pos_y = py;
    if (f == FUNC_INSERT && !body_taken[body]) begin
      body_taken[body] = 1'b1;
      taken_cnt++;
    end
    if (f == FUNC_CLEAR) begin
      foreach (body_taken[i]) body_taken[i] = 1'b0;
      taken_cnt = 0;
    end
    if (f != FUNC_NONE) useful_cmds++;
    cmds_queued++;
    cmds_waiting.push_back(cmd);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (words_accepted != cmds_queued || replies_due.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_GRID_COLS:  cols_reg  = val;
      CFG_GRID_ROWS:  rows_reg  = val;
      CFG_CELL_SHIFT: shift_reg = val[SHIFT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_geometry(input logic [5:0] cols, input logic [5:0] rows,
                              input logic [3:0] shift);
    wait_drained();
    repeat (8) @(posedge clk_i);
    write_reg(CFG_GRID_COLS, cols);
    write_reg(CFG_GRID_ROWS, rows);
    write_reg(CFG_CELL_SHIFT, {2'b00, shift});
    @(posedge clk_i);
    geometry_sets++;
  endtask

  function automatic logic [5:0] pick_dim();
    if ($urandom_range(99) < 85) return 6'($urandom_range(1, 10));
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic logic [BODY_W-1:0] fresh_body();
    int unsigned b;
    b = $urandom_range(DEF_MAX_BODIES - 1);
    while (body_taken[b]) b = (b + 1) % DEF_MAX_BODIES;
    return BODY_W'(b);
  endfunction

  // mostly around a cluster cell so that neighbour pairs show up
  function automatic logic [POS_W-1:0] near_pos(int center, int unsigned lim);
    int slot;
    int p;
    if ($urandom_range(5) == 0) return POS_W'($urandom);
    slot = center + int'($urandom_range(2)) - 1;
    if (slot < 0) slot = 0;
    if (slot > int'(lim) - 1) slot = int'(lim) - 1;
    p = (slot << shift_reg) + int'($urandom_range((1 << shift_reg) - 1));
    if (p > 65535) p = 65535;
    return POS_W'(p);
  endfunction

  task automatic run_frame();
    int unsigned       cols;
    int unsigned       rows;
    int                cc;
    int                cr;
    int unsigned       n_bodies;
    int unsigned       reqs;
    int unsigned       chunk;
    logic [BODY_W-1:0] body;
    cols = used_dim(cols_reg, DEF_MAX_COLS);
    rows = used_dim(rows_reg, DEF_MAX_ROWS);
    cc = int'($urandom_range(cols - 1));
    cr = int'($urandom_range(rows - 1));
    if ($urandom_range(1) == 0 || taken_cnt > 900)
      queue_cmd(FUNC_CLEAR, 10'($urandom), POS_W'($urandom), POS_W'($urandom));
    n_bodies = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 14);
    repeat (n_bodies) begin
      // now and then a random body, which may be one already inserted and so relinks it
      if (taken_cnt != 0 && $urandom_range(24) == 0) body = BODY_W'($urandom);
      else body = fresh_body();
      queue_cmd(FUNC_INSERT, body, near_pos(cc, cols), near_pos(cr, rows));
      if ($urandom_range(15) == 0)
        queue_cmd(FUNC_NONE, 10'($urandom), POS_W'($urandom), POS_W'($urandom));
    end
    reqs = 0;
    do begin
      chunk = $urandom_range(1, 12);
      repeat (chunk)
        queue_cmd(FUNC_NEXT_PAIR, 10'($urandom), POS_W'($urandom), POS_W'($urandom));
      reqs += chunk;
      if ($urandom_range(19) == 0)
        queue_cmd(FUNC_INSERT, fresh_body(), near_pos(cc, cols), near_pos(cr, rows));
      if ($urandom_range(9) == 0)
        queue_cmd(FUNC_NONE, 10'($urandom), POS_W'($urandom), POS_W'($urandom));
      wait_drained();
    end while (!scan_over && reqs < 90);
    repeat ($urandom_range(1, 2))
      queue_cmd(FUNC_NEXT_PAIR, 10'($urandom), POS_W'($urandom), POS_W'($urandom));
  endtask

  initial begin
    int unsigned frame_no;
    foreach (head_of_cell[i]) head_of_cell[i] = NO_BODY;
    foreach (next_in_cell[i]) next_in_cell[i] = NO_BODY;
    restart_scan();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk on an empty grid, then bodies in a corner cell and its three in-grid neighbours
    queue_cmd(FUNC_NEXT_PAIR, '0, '0, '0);
    queue_cmd(FUNC_NEXT_PAIR, '0, '0, '0);
    queue_cmd(FUNC_NONE, 10'h3FF, 17'h1FFFF, 17'h1FFFF);
    queue_cmd(FUNC_INSERT, 10'd0, 17'h10000, 17'h1FFFF);
    queue_cmd(FUNC_INSERT, 10'd1023, 17'h00000, 17'h00000);
    queue_cmd(FUNC_INSERT, 10'd5, 17'h0FFFF, 17'h0FFFF);
    queue_cmd(FUNC_INSERT, 10'd6, 17'd1024, 17'd0);
    queue_cmd(FUNC_INSERT, 10'd7, 17'd0, 17'd1024);
    queue_cmd(FUNC_INSERT, 10'd8, 17'd1024, 17'd1024);
    repeat (4) queue_cmd(FUNC_NEXT_PAIR, '0, '0, '0);
    queue_cmd(FUNC_NONE, '0, '0, '0);
    // body 6 again, now in cell 0: the two lists share a tail
    queue_cmd(FUNC_INSERT, 10'd6, 17'd5, 17'd7);
    repeat (5) queue_cmd(FUNC_NEXT_PAIR, '0, '0, '0);
    queue_cmd(FUNC_CLEAR, '0, '0, '0);
    queue_cmd(FUNC_NEXT_PAIR, '0, '0, '0);
    wait_drained();

    frame_no = 0;
    while (useful_cmds < RUN_CMDS) begin
      if (useful_cmds < RUN_CMDS / 3) begin
        send_gap_pct = 27;
        recv_gap_pct = 60;
      end else if (useful_cmds < 2 * RUN_CMDS / 3) begin
        send_gap_pct = 60;
        recv_gap_pct = 27;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      case (frame_no)
        0: set_geometry(6'd0, 6'd63, 4'd0);
        1: set_geometry(6'd63, 6'd0, 4'd15);
        2: set_geometry(6'd1, 6'd1, 4'd3);
        3: begin
          set_geometry(6'd32, 6'd32, 4'd10);
          write_reg(CFG_SPARE_IDX, 6'($urandom));
        end
        default: begin
          // without a clear, bodies keep their old cell numbers
          if ($urandom_range(2) == 0)
            set_geometry(pick_dim(), pick_dim(), 4'($urandom_range(15)));
        end
      endcase
      run_frame();
      frame_no++;
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (replies_due.size() != 0) begin
      $error("%0d reply words never arrived", replies_due.size());
      error_cnt++;
    end
    $display("run: %0d commands in %0d frames over %0d grid settings",
             cmds_queued, frame_no, geometry_sets);
    $display("run: %0d candidate pairs and %0d finished-walk replies checked",
             pairs_seen, walks_done);
    if (error_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/ugpf_pkg.sv
src/ugpf_ram.sv
src/uniform_grid_pair_finder.sv
src/ugpf_checker.sv
test/uniform_grid_pair_finder_test.sv
